[rtl/audio_peak_normalizer_macros.svh]
// Assertion shorthands shared by the RTL of the peak normalizer.
// Every property is clocked on i_clk and is off while i_rst_n is low.
`ifndef AUDIO_PEAK_NORMALIZER_MACROS_SVH
`define AUDIO_PEAK_NORMALIZER_MACROS_SVH

// Same-cycle implication.
`define APN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define APN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/apn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package apn_pkg;

    // Default sample width and the fixed width of the target register.
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int TARGET_BITS     = 15;
    localparam int CFG_DATA_BITS   = 15;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [TARGET_BITS-1:0] TARGET_RESET = 15'h7FFF;

    // Item opcodes.
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_SCALE   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET = 1'b1;

    // Status of the queue between the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

`default_nettype wire

[rtl/apn_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input stage: takes a request, splits the sample into sign and magnitude and
// offers the classified item to the queue.
module apn_front #(
    parameter int SAMPLE_BITS = apn_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic                   i_opcode,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last,
    input  wire apn_pkg::t_q_flags      i_q_flags,
    output logic                        o_push,
    output logic [SAMPLE_BITS+2:0]      o_item
);

    logic                   r_valid;
    logic                   n_valid;
    logic                   r_opcode;
    logic                   r_last;
    logic                   r_neg;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic                   w_accept;
    logic                   w_neg;
    logic [SAMPLE_BITS-1:0] w_mag;

    assign o_stall  = r_valid && i_q_flags.full;
    assign o_push   = r_valid && !i_q_flags.full;
    assign w_accept = i_valid && !o_stall;

    // The most negative sample wraps to 2^(SAMPLE_BITS-1), which is its true magnitude.
    assign w_neg = i_sample[SAMPLE_BITS-1];
    assign w_mag = w_neg ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;

    assign o_item = {r_opcode, r_last, r_neg, r_mag};

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_opcode <= i_opcode;
            r_last   <= i_last;
            r_neg    <= w_neg;
            r_mag    <= w_mag;
        end
    end

endmodule

`default_nettype wire

[rtl/apn_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Small first-in first-out queue of classified items.
module apn_queue #(
    parameter int WIDTH = apn_pkg::DEF_SAMPLE_BITS + 3,
    parameter int DEPTH = apn_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output apn_pkg::t_q_flags     o_flags
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_flags.full  = (r_count == CW'(DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign w_do_push     = i_push && !o_flags.full;
    assign w_do_pop      = i_pop && !o_flags.empty;
    assign o_data        = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/apn_back.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "audio_peak_normalizer_macros.svh"

// Execution part: keeps the peak, multiplies by the target, divides by the peak
// one quotient bit per cycle and holds the result in the output register.
module apn_back #(
    parameter int SAMPLE_BITS = apn_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [apn_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [apn_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic [SAMPLE_BITS+2:0]            i_item,
    input  wire apn_pkg::t_q_flags                 i_q_flags,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [SAMPLE_BITS-1:0]                 o_scaled_sample,
    output logic                                   o_last_out,
    output logic                                   o_zero_peak
);

    localparam int SB     = SAMPLE_BITS;
    localparam int TGT_W  = (SB > apn_pkg::TARGET_BITS) ? SB : apn_pkg::TARGET_BITS;
    localparam int PROD_W = SB + TGT_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [SB-1:0] HALF     = SB'(1) << (SB - 1);
    localparam logic [SB-1:0] HALF_M1  = HALF - SB'(1);

    apn_pkg::t_back_state r_state;
    apn_pkg::t_back_state n_state;

    logic                             r_enable;
    logic [apn_pkg::TARGET_BITS-1:0]  r_target;
    logic [SB-1:0]                    r_peak;
    logic [SB-1:0]                    n_peak;
    logic                             r_out_valid;
    logic                             n_out_valid;

    logic [SB-1:0]     r_mag;
    logic [SB-1:0]     n_mag;
    logic [TGT_W-1:0]  r_tgt;
    logic [TGT_W-1:0]  n_tgt;
    logic [SB-1:0]     r_den;
    logic [SB-1:0]     n_den;
    logic              r_neg;
    logic              n_neg;
    logic              r_last;
    logic              n_last;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] n_acc;
    logic [SB-1:0]     r_rem;
    logic [SB-1:0]     n_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [SB-1:0]     r_out_sample;
    logic [SB-1:0]     n_out_sample;
    logic              r_out_last;
    logic              n_out_last;
    logic              r_out_zero;
    logic              n_out_zero;

    logic          w_is_scale;
    logic          w_is_last;
    logic          w_item_neg;
    logic [SB-1:0] w_item_mag;
    logic [SB:0]   w_rem_sh;
    logic [SB:0]   w_den_ext;
    logic          w_ge;
    logic [SB:0]   w_rem_diff;
    logic          w_over_pos;
    logic          w_over_neg;
    logic [SB-1:0] w_mag_sat;
    logic [SB-1:0] w_result;
    logic          w_zero;
    logic          w_out_free;

    assign w_is_scale = (i_item[SB+2] == apn_pkg::OP_SCALE);
    assign w_is_last  = i_item[SB+1];
    assign w_item_neg = i_item[SB];
    assign w_item_mag = i_item[SB-1:0];

    assign o_pop      = (r_state == apn_pkg::ST_IDLE) && !i_q_flags.empty;
    assign w_out_free = !r_out_valid || !i_stall;

    // One restoring division step: for a nonzero divisor the remainder stays below the divisor.
    assign w_rem_sh   = {r_rem, r_acc[PROD_W-1]};
    assign w_den_ext  = {1'b0, r_den};
    assign w_ge       = (w_rem_sh >= w_den_ext);
    assign w_rem_diff = w_rem_sh - w_den_ext;

    // Saturate the quotient to the signed sample range and apply the sign.
    assign w_over_pos = |r_acc[PROD_W-1:SB-1];
    assign w_over_neg = (|r_acc[PROD_W-1:SB]) || (r_acc[SB-1] && (|r_acc[SB-2:0]));
    always_comb begin
        if (r_neg) begin
            w_mag_sat = w_over_neg ? HALF : r_acc[SB-1:0];
        end else begin
            w_mag_sat = w_over_pos ? HALF_M1 : r_acc[SB-1:0];
        end
    end
    assign w_result = r_neg ? (~w_mag_sat + SB'(1)) : w_mag_sat;
    assign w_zero   = (r_den == '0);

    always_comb begin
        n_state      = r_state;
        n_peak       = r_peak;
        n_out_valid  = r_out_valid && i_stall;
        n_mag        = r_mag;
        n_tgt        = r_tgt;
        n_den        = r_den;
        n_neg        = r_neg;
        n_last       = r_last;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        n_out_zero   = r_out_zero;
        unique case (r_state)
            apn_pkg::ST_IDLE: begin
                if (o_pop) begin
                    if (!w_is_scale) begin
                        if (w_item_mag > r_peak) begin
                            n_peak = w_item_mag;
                        end
                    end else begin
                        n_mag  = w_item_mag;
                        n_neg  = w_item_neg;
                        n_last = w_is_last;
                        n_den  = r_peak;
                        n_tgt  = r_enable ? TGT_W'(r_target) : TGT_W'(r_peak);
                        if (w_is_last) begin
                            n_peak = '0;
                        end
                        n_state = apn_pkg::ST_MUL;
                    end
                end
            end
            apn_pkg::ST_MUL: begin
                n_acc   = PROD_W'(r_mag) * PROD_W'(r_tgt);
                n_rem   = '0;
                n_cnt   = CNT_W'(PROD_W - 1);
                n_state = apn_pkg::ST_DIV;
            end
            apn_pkg::ST_DIV: begin
                n_acc = {r_acc[PROD_W-2:0], w_ge};
                n_rem = w_ge ? w_rem_diff[SB-1:0] : w_rem_sh[SB-1:0];
                if (r_cnt == '0) begin
                    n_state = apn_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            apn_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_zero ? '0 : w_result;
                    n_out_last   = r_last;
                    n_out_zero   = w_zero;
                    n_state      = apn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = apn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apn_pkg::ST_IDLE;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_target    <= apn_pkg::TARGET_RESET;
        end else begin
            r_state     <= n_state;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    apn_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                    apn_pkg::CFG_TARGET: r_target <= i_cfg_data[apn_pkg::TARGET_BITS-1:0];
                    default:             r_enable <= r_enable;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag        <= n_mag;
        r_tgt        <= n_tgt;
        r_den        <= n_den;
        r_neg        <= n_neg;
        r_last       <= n_last;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        r_out_zero   <= n_out_zero;
    end

    assign o_valid         = r_out_valid;
    assign o_scaled_sample = r_out_sample;
    assign o_last_out      = r_out_last;
    assign o_zero_peak     = r_out_zero;

    `APN_ASSERT_NEXT(a_last_clears_peak, o_pop && w_is_scale && w_is_last, r_peak == '0, "peak not cleared by last scale request")
    `APN_ASSERT_NEXT(a_peak_monotone, !(o_pop && w_is_scale && w_is_last), r_peak >= $past(r_peak), "peak dropped without a last scale request")
    `APN_ASSERT_NEXT(a_div_starts, r_state == apn_pkg::ST_MUL, r_state == apn_pkg::ST_DIV && r_cnt == CNT_W'(PROD_W - 1), "division did not start with a full count")
    `APN_ASSERT_NOW(a_zero_peak_output, r_out_valid && r_out_zero, r_out_sample == '0, "zero peak result carries a nonzero sample")

endmodule

`default_nettype wire

[rtl/audio_peak_normalizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-pass peak normalizer for signed audio samples. Measure requests (opcode 0) update the
// running peak magnitude and produce no output; scale requests (opcode 1) each produce one
// output equal to sample * target / peak, truncated toward zero and saturated to the sample
// range, where the target is target_peak when normalize_enable is set and the peak itself
// otherwise (an exact copy). A zero peak forces the output to 0 and raises zero_peak, and a
// scale request marked last clears the peak once it has been used. An input stage and a
// two-entry queue decouple the input handshake from the execution part, so requests are
// taken while a result still waits on a stalled output. In the execution part a scale request
// is fetched from the queue, multiplied by the target, divided by the peak in the bit-serial
// restoring divider and loaded into the output register once that register is free; no new
// request is fetched from the queue until then. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module audio_peak_normalizer #(
    parameter int SAMPLE_BITS = apn_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [apn_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [apn_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // Input request channel.
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_opcode,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  wire logic                               i_last,
    // Result request channel.
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [SAMPLE_BITS-1:0]           o_scaled_sample,
    output logic                                    o_last_out,
    output logic                                    o_zero_peak
);

    localparam int ITEM_W = SAMPLE_BITS + 3;

    // Classified requests travel as {opcode, last, sign, magnitude}.
    logic              w_push;
    logic              w_pop;
    logic [ITEM_W-1:0] w_front_item;
    logic [ITEM_W-1:0] w_queue_item;
    apn_pkg::t_q_flags w_q_flags;

    apn_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_opcode  (i_opcode),
        .i_sample  (i_sample),
        .i_last    (i_last),
        .i_q_flags (w_q_flags),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    apn_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (apn_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .i_pop   (w_pop),
        .o_data  (w_queue_item),
        .o_flags (w_q_flags)
    );

    // The execution part owns the configuration registers and the peak.
    apn_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_item          (w_queue_item),
        .i_q_flags       (w_q_flags),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_scaled_sample (o_scaled_sample),
        .o_last_out      (o_last_out),
        .o_zero_peak     (o_zero_peak)
    );

endmodule

`default_nettype wire
